// ----- rtl/adsr_pkg.sv -----
// Shared types and constants for the ADSR envelope generator core.
// Used by the controller, the datapath and the top level; no dependencies.
package adsr_pkg;

    localparam int LEN_BITS_DEFAULT   = 20;
    localparam int LEVEL_FRAC_DEFAULT = 24;

    localparam int LVL_W         = 25;
    localparam int FAC_W         = 17;
    localparam int OUT_W         = 26;
    localparam int STEP_W        = 27;
    localparam int FAC_ONE_SHIFT = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    localparam logic [31:0] RST_ATTACK_PEAK   = 32'd16777216;
    localparam logic [31:0] RST_DECAY_LEVEL   = 32'd11744051;
    localparam logic [31:0] RST_SUSTAIN_LEVEL = 32'd8388608;
    localparam logic [31:0] RST_ATTACK_LEN    = 32'd5999;
    localparam logic [31:0] RST_DECAY_LEN     = 32'd11999;
    localparam logic [31:0] RST_SUSTAIN_LEN   = 32'd47999;
    localparam logic [31:0] RST_RELEASE_LEN   = 32'd2399;
    localparam logic [31:0] RST_HOLD_FACTOR   = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_PEAK   = 3'd0,
        CFG_DECAY_LEVEL   = 3'd1,
        CFG_SUSTAIN_LEVEL = 3'd2,
        CFG_ATTACK_LEN    = 3'd3,
        CFG_DECAY_LEN     = 3'd4,
        CFG_SUSTAIN_LEN   = 3'd5,
        CFG_RELEASE_LEN   = 3'd6,
        CFG_HOLD_FACTOR   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_ATTACK  = 2'd0,
        ST_DECAY   = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_TRIGGER = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_TRIGGER    = 3'd1,
        OP_RELEASE    = 3'd2,
        OP_TICK_SPENT = 3'd3,
        OP_TICK       = 3'd4
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
        logic   step_load;
        logic   mul_load;
        logic   sat_load;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  stage_attack;
        logic  tick_done;
        logic  tick_div;
        logic  tick_mul;
        logic  div_done;
        logic  out_free;
    } dp_status_t;

endpackage

// ----- rtl/adsr_div.sv -----
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero; a zero divisor gives zero. No dependencies.
module adsr_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;

    logic [NUM_W-1:0] num_abs;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] q_ext;

    assign num_abs  = num[NUM_W-1] ? (-num) : num;
    assign rem_sh   = {rem_reg, q_reg[MAG_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg    <= num_abs[MAG_W-1:0];
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= num[NUM_W-1];
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            q_reg   <= {q_reg[MAG_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign q_ext = {1'b0, q_reg};
    assign done  = done_reg;
    assign quot  = zero_reg ? '0 : (neg_reg ? signed'(-q_ext) : signed'(q_ext));

endmodule

// ----- rtl/adsr_ctrl.sv -----
// Sequencing state machine for the envelope core: accepts beats, issues
// datapath commands, waits on the divider and the output slot. Uses adsr_pkg.
module adsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  adsr_pkg::dp_status_t status,
    output adsr_pkg::dp_cmd_t    cmd
);
    import adsr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_SAT  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (status.kind)
                    KIND_TRIGGER: begin
                        if (!status.stage_attack) begin
                            cmd.op     = OP_TRIGGER;
                            state_next = S_DIV;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_RELEASE: begin
                        cmd.op     = OP_RELEASE;
                        state_next = S_DIV;
                    end
                    KIND_TICK: begin
                        if (status.tick_done) begin
                            cmd.op     = OP_TICK_SPENT;
                            state_next = S_EMIT;
                        end else begin
                            cmd.op = OP_TICK;
                            priority if (status.tick_div) begin
                                state_next = S_DIV;
                            end else if (status.tick_mul) begin
                                state_next = S_MUL;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (status.div_done) begin
                    cmd.step_load = 1'b1;
                    state_next    = (status.kind == KIND_TICK) ? S_EMIT : S_IDLE;
                end
            end
            S_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = S_SAT;
            end
            S_SAT: begin
                cmd.sat_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/adsr_dp.sv -----
// Envelope datapath: settings registers, position, stage, level and step,
// hold multiplier, result and output registers. Uses adsr_pkg and adsr_div.
module adsr_dp #(
    parameter int LEN_BITS        = adsr_pkg::LEN_BITS_DEFAULT,
    parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [adsr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [adsr_pkg::S_TUSER_W-1:0]   s_tuser,
    input  adsr_pkg::dp_cmd_t                cmd,
    output adsr_pkg::dp_status_t             status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [adsr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import adsr_pkg::*;

    localparam int LEN_W  = LEN_BITS;
    localparam int SUM_W  = LEN_BITS + 2;
    localparam int POS_W  = LEN_BITS + 3;
    localparam int PROD_W = OUT_W + FAC_W;
    localparam int HOLD_W = PROD_W - FAC_ONE_SHIFT;
    localparam int FLUSH_LIMIT = (1 << LEVEL_FRAC_BITS) / 1000000;

    logic [LVL_W-1:0] attack_peak_reg, decay_level_reg, sustain_level_reg;
    logic [LEN_W-1:0] attack_len_reg, decay_len_reg, sustain_len_reg, release_len_reg;
    logic [FAC_W-1:0] hold_factor_reg;

    logic [POS_W-1:0]        pos_reg, pos_next;
    stage_t                  stage_reg, stage_next;
    logic signed [OUT_W-1:0] level_reg, level_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic                    spent_reg, spent_next;

    kind_t kind_reg;
    logic  held_reg;

    logic [PROD_W-1:0]    prod_reg;
    logic                 flush_reg;
    logic [M_TDATA_W-1:0] res_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_valid_reg;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W+1:0] v);
        logic signed [OUT_W-1:0] r;
        if ((v[OUT_W+1:OUT_W-1] == 3'b000) || (v[OUT_W+1:OUT_W-1] == 3'b111)) begin
            r = v[OUT_W-1:0];
        end else if (v[OUT_W+1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

    // settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_peak_reg   <= RST_ATTACK_PEAK[LVL_W-1:0];
            decay_level_reg   <= RST_DECAY_LEVEL[LVL_W-1:0];
            sustain_level_reg <= RST_SUSTAIN_LEVEL[LVL_W-1:0];
            attack_len_reg    <= RST_ATTACK_LEN[LEN_W-1:0];
            decay_len_reg     <= RST_DECAY_LEN[LEN_W-1:0];
            sustain_len_reg   <= RST_SUSTAIN_LEN[LEN_W-1:0];
            release_len_reg   <= RST_RELEASE_LEN[LEN_W-1:0];
            hold_factor_reg   <= RST_HOLD_FACTOR[FAC_W-1:0];
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_ATTACK_PEAK:   attack_peak_reg   <= cfg_wr_data[LVL_W-1:0];
                CFG_DECAY_LEVEL:   decay_level_reg   <= cfg_wr_data[LVL_W-1:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wr_data[LVL_W-1:0];
                CFG_ATTACK_LEN:    attack_len_reg    <= cfg_wr_data[LEN_W-1:0];
                CFG_DECAY_LEN:     decay_len_reg     <= cfg_wr_data[LEN_W-1:0];
                CFG_SUSTAIN_LEN:   sustain_len_reg   <= cfg_wr_data[LEN_W-1:0];
                CFG_RELEASE_LEN:   release_len_reg   <= cfg_wr_data[LEN_W-1:0];
                CFG_HOLD_FACTOR:   hold_factor_reg   <= cfg_wr_data[FAC_W-1:0];
                default: ;
            endcase
        end
    end

    // stage boundaries
    logic [SUM_W-1:0] ad_sum, s3_sum, total_sum;
    logic [POS_W-1:0] ad_ext, s3_ext, total_ext, att_ext;

    assign ad_sum    = SUM_W'(attack_len_reg) + SUM_W'(decay_len_reg);
    assign s3_sum    = ad_sum + SUM_W'(sustain_len_reg);
    assign total_sum = s3_sum + SUM_W'(release_len_reg);
    assign att_ext   = POS_W'(attack_len_reg);
    assign ad_ext    = POS_W'(ad_sum);
    assign s3_ext    = POS_W'(s3_sum);
    assign total_ext = POS_W'(total_sum);

    // tick decode
    logic [POS_W-1:0] pos_inc, tick_pos, rel_pos;
    logic held_hit, att_hit, dec_hit, sust_hit, tick_div, tick_mul;
    stage_t tick_stage;
    logic signed [OUT_W+1:0] tick_sum;
    logic signed [OUT_W-1:0] tick_sample;

    assign pos_inc   = pos_reg + 1'b1;
    assign held_hit  = held_reg && (pos_inc == s3_ext);
    assign att_hit   = (stage_reg == ST_ATTACK) && (pos_inc == att_ext);
    assign dec_hit   = (stage_reg == ST_DECAY) && (pos_inc == ad_ext);
    assign sust_hit  = (stage_reg == ST_SUSTAIN) && (pos_inc == s3_ext);
    assign tick_div  = att_hit || dec_hit || (sust_hit && !held_reg);
    assign tick_mul  = sust_hit && held_reg;
    assign tick_pos  = tick_mul ? pos_reg : pos_inc;
    assign rel_pos   = (pos_reg != s3_ext) ? s3_ext : pos_reg;

    always_comb begin
        priority if (att_hit) begin
            tick_stage = ST_DECAY;
        end else if (dec_hit) begin
            tick_stage = ST_SUSTAIN;
        end else if (sust_hit && !held_reg) begin
            tick_stage = ST_RELEASE;
        end else begin
            tick_stage = stage_reg;
        end
    end

    assign tick_sum    = (OUT_W+2)'(level_reg) + (OUT_W+2)'(step_reg);
    assign tick_sample = held_hit ? level_reg : sat_out(tick_sum);

    // step divider
    logic                     div_start, div_done;
    logic signed [STEP_W-1:0] div_num, div_quot;
    logic        [LEN_W-1:0]  div_den;
    logic signed [STEP_W-1:0] n_attack, n_decay, n_sustain, n_neg_level, n_neg_sust;

    assign n_attack    = signed'(STEP_W'(attack_peak_reg));
    assign n_decay     = signed'(STEP_W'(decay_level_reg) - STEP_W'(attack_peak_reg));
    assign n_sustain   = signed'(STEP_W'(sustain_level_reg) - STEP_W'(decay_level_reg));
    assign n_neg_level = -(STEP_W'(level_reg));
    assign n_neg_sust  = signed'(-STEP_W'(sustain_level_reg));

    always_comb begin
        div_start = 1'b0;
        div_num   = n_neg_sust;
        div_den   = release_len_reg;
        unique case (cmd.op)
            OP_TRIGGER: begin
                div_start = 1'b1;
                div_num   = n_attack;
                div_den   = attack_len_reg;
            end
            OP_RELEASE: begin
                div_start = 1'b1;
                div_num   = (pos_reg != s3_ext) ? n_neg_level : n_neg_sust;
            end
            OP_TICK: begin
                div_start = tick_div;
                priority if (att_hit) begin
                    div_num = n_decay;
                    div_den = decay_len_reg;
                end else if (dec_hit) begin
                    div_num = n_sustain;
                    div_den = sustain_len_reg;
                end else begin
                    div_num = n_neg_sust;
                end
            end
            default: ;
        endcase
    end

    adsr_div #(
        .NUM_W (STEP_W),
        .DEN_W (LEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // hold decay
    logic [OUT_W-1:0]         level_mag;
    logic [HOLD_W:0]          hold_mag;
    logic signed [OUT_W+1:0]  hold_val;
    logic signed [OUT_W-1:0]  hold_level;

    assign level_mag  = level_reg[OUT_W-1] ? OUT_W'(-level_reg) : OUT_W'(level_reg);
    assign hold_mag   = {1'b0, prod_reg[PROD_W-1:FAC_ONE_SHIFT]};
    assign hold_val   = level_reg[OUT_W-1] ? -(OUT_W+2)'(hold_mag) : (OUT_W+2)'(hold_mag);
    assign hold_level = flush_reg ? '0 : sat_out(hold_val);

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_reg  <= PROD_W'(level_mag) * PROD_W'(hold_factor_reg);
            flush_reg <= level_mag <= OUT_W'(FLUSH_LIMIT);
        end
    end

    // envelope state
    always_comb begin
        pos_next   = pos_reg;
        stage_next = stage_reg;
        level_next = level_reg;
        step_next  = step_reg;
        spent_next = spent_reg;
        unique case (cmd.op)
            OP_TRIGGER: begin
                pos_next   = '0;
                stage_next = ST_ATTACK;
                level_next = '0;
                spent_next = 1'b0;
            end
            OP_RELEASE: begin
                pos_next   = rel_pos;
                stage_next = ST_RELEASE;
                spent_next = rel_pos >= total_ext;
            end
            OP_TICK_SPENT: spent_next = 1'b1;
            OP_TICK: begin
                pos_next   = tick_pos;
                stage_next = tick_stage;
                level_next = tick_sample;
                spent_next = tick_pos >= total_ext;
            end
            default: ;
        endcase
        if (cmd.step_load) begin
            step_next = div_quot;
        end
        if (cmd.sat_load) begin
            level_next = hold_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            stage_reg <= ST_RELEASE;
            level_reg <= '0;
            step_reg  <= '0;
            spent_reg <= 1'b1;
        end else begin
            pos_reg   <= pos_next;
            stage_reg <= stage_next;
            level_reg <= level_next;
            step_reg  <= step_next;
            spent_reg <= spent_next;
        end
    end

    // input capture and result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_t'(s_tuser[1:0]);
            held_reg <= s_tdata[0];
        end
        if (cmd.op == OP_TICK_SPENT) begin
            res_reg <= {3'b000, 1'b1, stage_reg, {OUT_W{1'b0}}};
        end else if (cmd.op == OP_TICK) begin
            res_reg <= {3'b000, 1'b0, stage_reg, tick_sample};
        end
        if (cmd.emit) begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.kind         = kind_reg;
    assign status.stage_attack = (stage_reg == ST_ATTACK);
    assign status.tick_done    = spent_reg || (pos_reg >= total_ext);
    assign status.tick_div     = tick_div;
    assign status.tick_mul     = tick_mul;
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || m_tready;

endmodule

// ----- rtl/adsr_envelope_generator_core.sv -----
// Linear ADSR envelope generator, top level.
// Input beats (s_): tuser[1:0] = kind (sample tick, trigger, release),
// tdata[0] = gate held. One result beat (m_) per sample tick only.
// Settings are written through cfg_wr_*; the user must do so only while no
// beat is in flight, as the block itself does not enforce it. A plain tick
// goes from S_IDLE through S_EXEC to S_EMIT; m_tvalid rises in the same
// cycle that s_tready returns, and no new beat is taken before then.
// A tick that ends a stage, a trigger outside attack and a release run the
// step divider, one quotient bit a cycle; a held tick at sustain end runs
// the hold multiply through S_MUL and S_SAT instead.
// The output register decouples the sides: the next beat is taken while a
// result waits; a stalled receiver only holds the block at the following
// result. Reset (aresetn low, synchronous) loads default settings and
// leaves the envelope spent in release, so ticks give zero with finished.
// Depends on adsr_pkg, adsr_ctrl, adsr_dp, adsr_div.
module adsr_envelope_generator_core #(
    parameter int LEN_BITS        = adsr_pkg::LEN_BITS_DEFAULT,
    parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adsr_pkg::S_TDATA_W-1:0]  s_tdata,  // [0] sustain_held, rest zero
    input  logic [adsr_pkg::S_TUSER_W-1:0]  s_tuser,  // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [adsr_pkg::M_TDATA_W-1:0]  m_tdata   // [25:0] level, [27:26] stage,
                                                      // [28] finished, rest zero
);
    import adsr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp #(
        .LEN_BITS        (LEN_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ----- test/adsr_envelope_generator_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for adsr_envelope_generator_core: bursty stream driver, stalling
// sample monitor and an in-bench envelope predictor, run over many register settings.
// Depends on adsr_pkg and the core RTL only.
module adsr_envelope_generator_core_test;
    import adsr_pkg::*;

    localparam int NUM_SETTINGS = 1 << CFG_IDX_W;
    localparam int POS_W = LEN_BITS_DEFAULT + 3;
    localparam logic [CFG_DATA_W-1:0] LEN_MASK = (CFG_DATA_W'(1) << LEN_BITS_DEFAULT) - 1;
    localparam logic [CFG_DATA_W-1:0] FAC_MASK = (CFG_DATA_W'(1) << FAC_W) - 1;
    localparam int LEVEL_ONE = 1 << LEVEL_FRAC_DEFAULT;
    localparam int FACTOR_ONE = 1 << FAC_ONE_SHIFT;
    localparam longint FLUSH_LIMIT = longint'(LEVEL_ONE) / 1000000;
    localparam longint LVL_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint LVL_MIN = -(longint'(1) << (OUT_W - 1));
    localparam logic [S_TUSER_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_BEATS = 30;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    typedef struct packed {
        logic [S_TUSER_W-1:0] kind;
        logic                 held;
    } gate_event_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] level;
        stage_t                  stage;
        logic                    finished;
    } env_sample_t;

    gate_event_t event_q[$];
    env_sample_t sample_q[$];

    logic [CFG_DATA_W-1:0] setting [NUM_SETTINGS];
    logic [CFG_DATA_W-1:0] next_setting [NUM_SETTINGS];

    logic [POS_W-1:0] env_pos;
    stage_t           env_stage;
    int               env_step;
    int               env_level;
    bit               env_done;

    int mismatches = 0;
    int beats_in = 0;
    int samples_checked = 0;
    int held_samples = 0;
    int spent_samples = 0;
    int settings_applied = 0;
    int burst_left = 0;
    int gap_left = 0;
    int run_left = 0;
    int stall_left = 0;

    adsr_envelope_generator_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint cfg_val(cfg_idx_t idx);
        return longint'(setting[idx]);
    endfunction

    function automatic longint ramp_end();
        return cfg_val(CFG_ATTACK_LEN) + cfg_val(CFG_DECAY_LEN) + cfg_val(CFG_SUSTAIN_LEN);
    endfunction

    function automatic longint env_total();
        return ramp_end() + cfg_val(CFG_RELEASE_LEN);
    endfunction

    // signed division, truncating toward zero; zero length gives a flat ramp
    function automatic int ramp_slope(longint num, longint len);
        if (len == 0)
            return 0;
        return int'(num / len);
    endfunction

    function automatic int clamp_level(longint v);
        if (v > LVL_MAX)
            return int'(LVL_MAX);
        if (v < LVL_MIN)
            return int'(LVL_MIN);
        return int'(v);
    endfunction

    function automatic void enter_release();
        env_stage = ST_RELEASE;
        if (longint'(env_pos) != ramp_end()) begin
            env_pos = POS_W'(ramp_end());
            env_step = ramp_slope(-longint'(env_level), cfg_val(CFG_RELEASE_LEN));
        end else begin
            env_step = ramp_slope(-cfg_val(CFG_SUSTAIN_LEVEL), cfg_val(CFG_RELEASE_LEN));
        end
    endfunction

    function automatic void hold_level();
        longint mag;
        longint scaled;
        mag = (env_level < 0) ? -longint'(env_level) : longint'(env_level);
        if (mag > FLUSH_LIMIT) begin
            scaled = (mag * cfg_val(CFG_HOLD_FACTOR)) / longint'(FACTOR_ONE);
            env_level = clamp_level((env_level < 0) ? -scaled : scaled);
        end else begin
            env_level = 0;
        end
    endfunction

    function automatic void envelope_advance(logic [S_TUSER_W-1:0] kind, logic held);
        env_sample_t s;
        case (kind)
            KIND_TRIGGER: begin
                if (env_stage != ST_ATTACK) begin
                    env_pos = '0;
                    env_stage = ST_ATTACK;
                    env_step = ramp_slope(cfg_val(CFG_ATTACK_PEAK), cfg_val(CFG_ATTACK_LEN));
                    env_level = 0;
                    env_done = 1'b0;
                end
            end
            KIND_RELEASE: begin
                enter_release();
                env_done = longint'(env_pos) >= env_total();
            end
            KIND_TICK: begin
                s.stage = env_stage;
                if (env_done || longint'(env_pos) >= env_total()) begin
                    env_done = 1'b1;
                    s.level = '0;
                    s.finished = 1'b1;
                    spent_samples++;
                end else begin
                    env_pos = env_pos + 1'b1;
                    if (held && longint'(env_pos) == ramp_end()) begin
                        s.level = env_level[OUT_W-1:0];
                        held_samples++;
                    end else begin
                        env_level = clamp_level(longint'(env_level) + longint'(env_step));
                        s.level = env_level[OUT_W-1:0];
                    end
                    s.finished = 1'b0;
                    case (env_stage)
                        ST_ATTACK: begin
                            if (longint'(env_pos) == cfg_val(CFG_ATTACK_LEN)) begin
                                env_stage = ST_DECAY;
                                env_step = ramp_slope(cfg_val(CFG_DECAY_LEVEL)
                                                      - cfg_val(CFG_ATTACK_PEAK),
                                                      cfg_val(CFG_DECAY_LEN));
                            end
                        end
                        ST_DECAY: begin
                            if (longint'(env_pos) ==
                                cfg_val(CFG_ATTACK_LEN) + cfg_val(CFG_DECAY_LEN)) begin
                                env_stage = ST_SUSTAIN;
                                env_step = ramp_slope(cfg_val(CFG_SUSTAIN_LEVEL)
                                                      - cfg_val(CFG_DECAY_LEVEL),
                                                      cfg_val(CFG_SUSTAIN_LEN));
                            end
                        end
                        ST_SUSTAIN: begin
                            if (longint'(env_pos) == ramp_end()) begin
                                if (held) begin
                                    env_pos = env_pos - 1'b1;
                                    hold_level();
                                end else begin
                                    enter_release();
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (longint'(env_pos) >= env_total())
                        env_done = 1'b1;
                end
                sample_q.push_back(s);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge aclk) begin : drive_beats
        gate_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                envelope_advance(s_tuser, s_tdata[0]);
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0 || event_q.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    ev = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= ev.kind;
                    s_tdata <= {{(S_TDATA_W-1){1'b0}}, ev.held};
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_samples
        env_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("sample beat with nothing expected: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = sample_q.pop_front();
                samples_checked++;
                if (m_tdata[OUT_W-1:0] !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level,
                           $signed(m_tdata[OUT_W-1:0]));
                    mismatches++;
                end
                if (m_tdata[OUT_W+1:OUT_W] !== want.stage) begin
                    $error("stage: expected %0d, got %0d", want.stage, m_tdata[OUT_W+1:OUT_W]);
                    mismatches++;
                end
                if (m_tdata[OUT_W+2] !== want.finished) begin
                    $error("finished: expected %0b, got %0b", want.finished, m_tdata[OUT_W+2]);
                    mismatches++;
                end
            end
        end
        // receiver: runs of ready broken by stalls, some runs with no stall at all
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (run_left != 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(0, 24);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void add_event(logic [S_TUSER_W-1:0] kind, logic held);
        gate_event_t ev;
        ev.kind = kind;
        ev.held = held;
        event_q.push_back(ev);
    endfunction

    function automatic int cap(longint v, int lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    task automatic drain();
        do
            @(negedge aclk);
        while (event_q.size() != 0 || s_tvalid || sample_q.size() != 0);
        // triggers and releases give no sample, so let the divider finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_settings();
        cfg_idx_t idx;
        idx = idx.first();
        do begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= idx;
            cfg_wr_data <= next_setting[idx];
            case (idx)
                CFG_ATTACK_PEAK, CFG_DECAY_LEVEL, CFG_SUSTAIN_LEVEL:
                    setting[idx] = next_setting[idx];
                CFG_HOLD_FACTOR:
                    setting[idx] = next_setting[idx] & FAC_MASK;
                default:
                    setting[idx] = next_setting[idx] & LEN_MASK;
            endcase
            idx = idx.next();
        end while (idx != idx.first());
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    task automatic choose_settings(int flavour, bit alt);
        case (flavour)
            0: begin
                next_setting[CFG_ATTACK_PEAK] = $urandom_range(0, LEVEL_ONE);
                next_setting[CFG_DECAY_LEVEL] = $urandom_range(0, LEVEL_ONE);
                next_setting[CFG_SUSTAIN_LEVEL] = $urandom_range(0, LEVEL_ONE);
                next_setting[CFG_ATTACK_LEN] = $urandom_range(1, 6);
                next_setting[CFG_DECAY_LEN] = $urandom_range(1, 6);
                next_setting[CFG_SUSTAIN_LEN] = $urandom_range(1, 6);
                next_setting[CFG_RELEASE_LEN] = $urandom_range(1, 6);
                next_setting[CFG_HOLD_FACTOR] = $urandom_range(0, FACTOR_ONE);
            end
            1: begin
                next_setting[CFG_ATTACK_PEAK] = alt ? 0 : LEVEL_ONE;
                next_setting[CFG_DECAY_LEVEL] = alt ? LEVEL_ONE : 0;
                next_setting[CFG_SUSTAIN_LEVEL] = alt ? 0 : LEVEL_ONE;
                next_setting[CFG_ATTACK_LEN] = alt ? LEN_MASK : 1;
                next_setting[CFG_DECAY_LEN] = alt ? LEN_MASK : 1;
                next_setting[CFG_SUSTAIN_LEN] = alt ? LEN_MASK : 1;
                next_setting[CFG_RELEASE_LEN] = alt ? LEN_MASK : 1;
                next_setting[CFG_HOLD_FACTOR] = alt ? FACTOR_ONE : 0;
            end
            2: begin
                // zero-length stages and out-of-range levels
                next_setting[CFG_ATTACK_PEAK] = $urandom();
                next_setting[CFG_DECAY_LEVEL] = $urandom();
                next_setting[CFG_SUSTAIN_LEVEL] = $urandom();
                next_setting[CFG_ATTACK_LEN] = $urandom_range(0, 2);
                next_setting[CFG_DECAY_LEN] = $urandom_range(0, 2);
                next_setting[CFG_SUSTAIN_LEN] = $urandom_range(0, 2);
                next_setting[CFG_RELEASE_LEN] = $urandom_range(0, 2);
                next_setting[CFG_HOLD_FACTOR] = $urandom_range(0, FAC_MASK);
            end
            3: begin
                // full-width data, upper bits dropped by the narrower registers
                for (int i = 0; i < NUM_SETTINGS; i++)
                    next_setting[i] = $urandom();
            end
            default: begin
                next_setting[CFG_ATTACK_PEAK] = $urandom();
                next_setting[CFG_DECAY_LEVEL] = $urandom_range(0, LEVEL_ONE);
                next_setting[CFG_SUSTAIN_LEVEL] = alt ? '1 : $urandom_range(0, LEVEL_ONE);
                next_setting[CFG_ATTACK_LEN] = $urandom_range(1, 4);
                next_setting[CFG_DECAY_LEN] = $urandom_range(1, 4);
                next_setting[CFG_SUSTAIN_LEN] = $urandom_range(1, 4);
                next_setting[CFG_RELEASE_LEN] = $urandom_range(1, 4);
                case ($urandom_range(0, 3))
                    0: next_setting[CFG_HOLD_FACTOR] = FAC_MASK;
                    1: next_setting[CFG_HOLD_FACTOR] = FACTOR_ONE - 1;
                    2: next_setting[CFG_HOLD_FACTOR] = 1;
                    default: next_setting[CFG_HOLD_FACTOR] = $urandom_range(0, FAC_MASK);
                endcase
            end
        endcase
    endtask

    // mostly whole notes (trigger, gated ticks, a release most of the time, tail), the rest stray beats
    task automatic queue_notes(int budget);
        int n;
        int span;
        int tail;
        int ticks;
        int tail_ticks;
        bit gate;
        logic [S_TUSER_W-1:0] kind;
        n = 0;
        span = cap(ramp_end(), 24);
        tail = cap(cfg_val(CFG_RELEASE_LEN), 12) + 2;
        while (n < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                add_event(KIND_TRIGGER, $urandom_range(0, 1));
                ticks = $urandom_range(0, span + 8);
                gate = $urandom_range(0, 3) != 0;
                for (int i = 0; i < ticks; i++)
                    add_event(KIND_TICK, ($urandom_range(0, 7) == 0) ? !gate : gate);
                if ($urandom_range(0, 2) != 0)
                    add_event(KIND_RELEASE, $urandom_range(0, 1));
                tail_ticks = $urandom_range(1, tail);
                for (int i = 0; i < tail_ticks; i++)
                    add_event(KIND_TICK, $urandom_range(0, 1));
                n += ticks + tail_ticks + 2;
            end else begin
                kind = $urandom_range(0, 3);
                add_event(kind, $urandom_range(0, 1));
                if (kind != KIND_UNUSED)
                    n++;
            end
        end
    endtask

    initial begin : run_phases
        setting[CFG_ATTACK_PEAK] = RST_ATTACK_PEAK[CFG_DATA_W-1:0];
        setting[CFG_DECAY_LEVEL] = RST_DECAY_LEVEL[CFG_DATA_W-1:0];
        setting[CFG_SUSTAIN_LEVEL] = RST_SUSTAIN_LEVEL[CFG_DATA_W-1:0];
        setting[CFG_ATTACK_LEN] = RST_ATTACK_LEN[CFG_DATA_W-1:0];
        setting[CFG_DECAY_LEN] = RST_DECAY_LEN[CFG_DATA_W-1:0];
        setting[CFG_SUSTAIN_LEN] = RST_SUSTAIN_LEN[CFG_DATA_W-1:0];
        setting[CFG_RELEASE_LEN] = RST_RELEASE_LEN[CFG_DATA_W-1:0];
        setting[CFG_HOLD_FACTOR] = RST_HOLD_FACTOR[CFG_DATA_W-1:0];
        env_pos = '0;
        env_stage = ST_RELEASE;
        env_step = 0;
        env_level = 0;
        env_done = 1'b1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // out of reset the envelope is spent
        @(negedge aclk);
        add_event(KIND_TICK, 1'b0);
        add_event(KIND_RELEASE, 1'b1);
        add_event(KIND_TICK, 1'b1);
        drain();

        // short stages, peak at full scale, decay to zero, half-rate hold
        next_setting[CFG_ATTACK_PEAK] = LEVEL_ONE;
        next_setting[CFG_DECAY_LEVEL] = 0;
        next_setting[CFG_SUSTAIN_LEVEL] = LEVEL_ONE;
        next_setting[CFG_ATTACK_LEN] = 1;
        next_setting[CFG_DECAY_LEN] = 3;
        next_setting[CFG_SUSTAIN_LEN] = 2;
        next_setting[CFG_RELEASE_LEN] = 3;
        next_setting[CFG_HOLD_FACTOR] = FACTOR_ONE / 2;
        program_settings();
        @(negedge aclk);
        add_event(KIND_TRIGGER, 1'b0);
        add_event(KIND_TRIGGER, 1'b1);
        repeat (4) add_event(KIND_TICK, 1'b0);
        repeat (4) add_event(KIND_TICK, 1'b1);
        add_event(KIND_TICK, 1'b0);
        repeat (3) add_event(KIND_TICK, 1'b0);
        add_event(KIND_RELEASE, 1'b0);
        add_event(KIND_TRIGGER, 1'b0);
        add_event(KIND_TICK, 1'b1);
        add_event(KIND_RELEASE, 1'b1);
        repeat (2) add_event(KIND_TICK, 1'b0);
        add_event(KIND_UNUSED, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            choose_settings(p % 5, p >= 5);
            program_settings();
            @(negedge aclk);
            queue_notes(PHASE_BEATS);
            drain();
        end

        $display("Envelope run: %0d input beats over %0d register settings, %0d samples checked",
                 beats_in, settings_applied, samples_checked);
        $display("  %0d samples held at sustain end, %0d from a spent envelope",
                 held_samples, spent_samples);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- adsr_envelope_generator_core.f -----
rtl/adsr_pkg.sv
rtl/adsr_div.sv
rtl/adsr_ctrl.sv
rtl/adsr_dp.sv
rtl/adsr_envelope_generator_core.sv
test/adsr_envelope_generator_core_test.sv
